[rtl/core/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the ring buffer deque.
// Request, status and state codes, fixed payload widths and parameter defaults.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Parameter defaults.
  localparam int unsigned DepthDflt     = 16;
  localparam int unsigned DataWidthDflt = 32;

  // Fixed payload widths.
  localparam int unsigned ReqW  = 3;
  localparam int unsigned PosW  = 4;
  localparam int unsigned ItemW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned FillW = 5;

  typedef enum logic [ReqW-1:0] {
    ReqPushBack  = 3'd0,
    ReqPushFront = 3'd1,
    ReqPopBack   = 3'd2,
    ReqPopFront  = 3'd3,
    ReqGet       = 3'd4,
    ReqSet       = 3'd5
  } req_type_e;

  typedef enum logic [StatW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2,
    StatRange = 2'd3
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StBusy = 1'b1
  } rbd_state_e;

endpackage

[rtl/core/rbd_req_if.sv]
// ----------------------------------------------------------------------------
// rbd_req_if: request channel of the ring buffer deque.
// Valid/ready handshake with operation code, logical position and data word.
// ----------------------------------------------------------------------------
interface rbd_req_if
  import rbd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [PosW-1:0]  position;
  logic [ItemW-1:0] item_value;

  modport source (output valid, output req_type, output position, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

[rtl/core/rbd_rsp_if.sv]
// ----------------------------------------------------------------------------
// rbd_rsp_if: response channel of the ring buffer deque.
// Valid/ready handshake with returned word, status and fill count.
// ----------------------------------------------------------------------------
interface rbd_rsp_if
  import rbd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ItemW-1:0] data_out;
  logic [StatW-1:0] status;
  logic [FillW-1:0] fill_count;

  modport source (output valid, output data_out, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input fill_count,
                  output ready);
endinterface

[rtl/core/ring_buffer_deque_unit.sv]
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit: fixed-capacity double-ended queue in a ring RAM.
// Push and pop at both ends, read and replace at a logical position.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   -------  ---  -----------------  ------------------------------------
//   req_i    in   valid/ready        req_type, position, item_value
//   rsp_o    out  valid/ready        data_out, status, fill_count
//
// Each request is accepted in the idle state, which issues the RAM read or
// the push write, and completes in the busy state, which picks up the
// registered read data of the entry RAM.
// Reset clears the head index, the entry count and all handshake state; the
// RAM contents are left as they are, since only written entries are read.
// A stalled response sits in the output register while the next request is
// taken; the completing request then waits in the busy state until the
// output register frees up.
// ----------------------------------------------------------------------------
module ring_buffer_deque_unit
  import rbd_pkg::*;
#(
  parameter int unsigned Depth     = DepthDflt,
  parameter int unsigned DataWidth = DataWidthDflt
) (
  input logic        clk_i,
  input logic        rst_ni,
  rbd_req_if.sink    req_i,
  rbd_rsp_if.source  rsp_o
);

  // Width of a RAM address, of the entry count and of the wrap-around sum.
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = ((CntW > PosW) ? CntW : PosW) + 1;

  // Maps head plus an offset onto a RAM slot. Every caller keeps the sum
  // below twice the depth, so one compare and subtract does the modulo.
  function automatic logic [AddrW-1:0] wrap_slot(input logic [SumW-1:0] sum);
    logic [SumW-1:0] red;
    red = (sum >= SumW'(Depth)) ? (sum - SumW'(Depth)) : sum;
    return red[AddrW-1:0];
  endfunction

  // Control state.
  rbd_state_e       state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;

  // Request waiting for its RAM read data.
  status_e          pend_status_q, pend_status_d;
  logic [FillW-1:0] pend_fill_q, pend_fill_d;
  logic             pend_use_q, pend_use_d;
  logic             pend_set_q, pend_set_d;
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;
  logic [DataWidth-1:0] pend_val_q, pend_val_d;

  // Output register.
  logic             out_valid_q;
  logic [ItemW-1:0] out_data_q;
  status_e          out_status_q;
  logic [FillW-1:0] out_fill_q;

  // Handshake and RAM control.
  logic             accept;
  logic             finish;
  logic             acc_rd_en;
  logic [AddrW-1:0] acc_rd_addr;
  logic             acc_wr_en;
  logic [AddrW-1:0] acc_wr_addr;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataWidth-1:0] ram_wdata;
  logic [DataWidth-1:0] ram_rdata;
  logic [DataWidth-1:0] req_val;

  // Slot computations, all against the current head and count.
  logic             is_full;
  logic             is_empty;
  logic             pos_bad;
  logic [AddrW-1:0] slot_pos;
  logic [AddrW-1:0] slot_back;
  logic [AddrW-1:0] slot_last;
  logic [AddrW-1:0] head_dec;
  logic [AddrW-1:0] head_inc;

  assign accept = req_i.valid && req_i.ready;
  // The pending request completes once the output register is free or
  // is being emptied in this very cycle.
  assign finish = (state_q == StBusy) && (!out_valid_q || rsp_o.ready);

  assign req_val  = DataWidth'(req_i.item_value);
  assign is_full  = (count_q == CntW'(Depth));
  assign is_empty = (count_q == '0);
  assign pos_bad  = (SumW'(req_i.position) >= SumW'(count_q));

  assign slot_pos  = wrap_slot(SumW'(head_q) + SumW'(req_i.position));
  assign slot_back = wrap_slot(SumW'(head_q) + SumW'(count_q));
  assign slot_last = wrap_slot(SumW'(head_q) + SumW'(count_q) - SumW'(1));
  assign head_dec  = (head_q == '0) ? AddrW'(Depth - 1) : head_q - AddrW'(1);
  assign head_inc  = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + AddrW'(1);

  // Request decode. Head and count move at accept time, since they never
  // depend on the stored words; only the returned word waits for the RAM.
  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    pend_status_d = StatOk;
    pend_use_d    = 1'b0;
    pend_set_d    = 1'b0;
    pend_addr_d   = slot_pos;
    pend_val_d    = req_val;
    acc_rd_en     = 1'b0;
    acc_rd_addr   = slot_pos;
    acc_wr_en     = 1'b0;
    acc_wr_addr   = slot_back;
    unique case (req_type_e'(req_i.req_type))
      ReqPushBack: begin
        if (is_full) begin
          pend_status_d = StatFull;
        end else begin
          acc_wr_en   = 1'b1;
          acc_wr_addr = slot_back;
          count_d     = count_q + CntW'(1);
        end
      end
      ReqPushFront: begin
        if (is_full) begin
          pend_status_d = StatFull;
        end else begin
          acc_wr_en   = 1'b1;
          acc_wr_addr = head_dec;
          head_d      = head_dec;
          count_d     = count_q + CntW'(1);
        end
      end
      ReqPopBack: begin
        if (is_empty) begin
          pend_status_d = StatEmpty;
        end else begin
          acc_rd_en   = 1'b1;
          acc_rd_addr = slot_last;
          pend_use_d  = 1'b1;
          count_d     = count_q - CntW'(1);
        end
      end
      ReqPopFront: begin
        if (is_empty) begin
          pend_status_d = StatEmpty;
        end else begin
          acc_rd_en   = 1'b1;
          acc_rd_addr = head_q;
          pend_use_d  = 1'b1;
          head_d      = head_inc;
          count_d     = count_q - CntW'(1);
        end
      end
      ReqGet: begin
        if (pos_bad) begin
          pend_status_d = StatRange;
        end else begin
          acc_rd_en  = 1'b1;
          pend_use_d = 1'b1;
        end
      end
      ReqSet: begin
        // The old word is read now and the new one written back when the request
        // finishes, so no read ever meets a write to the same slot.
        if (pos_bad) begin
          pend_status_d = StatRange;
        end else begin
          acc_rd_en  = 1'b1;
          pend_use_d = 1'b1;
          pend_set_d = 1'b1;
        end
      end
      default: begin
        // Unused codes change nothing and report the current count.
      end
    endcase
    pend_fill_d = FillW'(count_d);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StBusy;
        end
      end
      StBusy: begin
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State outputs: request ready and the RAM write port. Push writes
  // happen in the accept cycle and set writes in the finish cycle, which
  // lie in different states and never collide.
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = acc_wr_addr;
    ram_wdata   = req_val;
    unique case (state_q)
      StIdle: begin
        req_i.ready = 1'b1;
        ram_we      = req_i.valid && acc_wr_en;
      end
      StBusy: begin
        ram_we    = finish && pend_set_q;
        ram_waddr = pend_addr_q;
        ram_wdata = pend_val_q;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  rbd_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && acc_rd_en),
    .raddr_i (acc_rd_addr),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      pend_set_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q     <= head_d;
        count_q    <= count_d;
        pend_set_q <= pend_set_d;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= pend_status_d;
      pend_fill_q   <= pend_fill_d;
      pend_use_q    <= pend_use_d;
      pend_addr_q   <= pend_addr_d;
      pend_val_q    <= pend_val_d;
    end
    if (finish) begin
      out_data_q   <= pend_use_q ? ItemW'(ram_rdata) : '0;
      out_status_q <= pend_status_q;
      out_fill_q   <= pend_fill_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.fill_count = out_fill_q;

endmodule

[rtl/core/rbd_ram.sv]
// ----------------------------------------------------------------------------
// rbd_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
